### rtl/brq_pkg.sv
// ----------------------------------------------------------------------------
// brq_pkg
// Shared constants, operation codes and the control type of the bitmap
// priority ready queue.
// ----------------------------------------------------------------------------
package brq_pkg;

   // default sizes handed to the top level parameters
   localparam int THREADS_DEF = 64;
   localparam int LEVELS_DEF  = 16;

   // fixed field widths of the stream payloads
   localparam int FUNC_W     = 2;
   localparam int TID_W      = 6;
   localparam int LVL_W      = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // operation codes
   localparam logic [FUNC_W-1:0] FN_ENQ_TAIL = 2'd0;
   localparam logic [FUNC_W-1:0] FN_ENQ_HEAD = 2'd1;
   localparam logic [FUNC_W-1:0] FN_DEQ      = 2'd2;
   localparam logic [FUNC_W-1:0] FN_REMOVE   = 2'd3;

   // update controls for the per-level head/tail table and bitmap
   typedef struct packed {
      logic head_we;
      logic tail_we;
      logic mask_set;
      logic mask_clr;
   } lvl_ctl_type;

endpackage

### rtl/brq_link_ram.sv
// ----------------------------------------------------------------------------
// brq_link_ram
// Simple dual-port link memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module brq_link_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/brq_level_table.sv
// ----------------------------------------------------------------------------
// brq_level_table
// Per-level head and tail pointers, the non-empty bitmap and the priority
// encoder that picks the highest non-empty level.
// ----------------------------------------------------------------------------
module brq_level_table
   import brq_pkg::*;
#(
   parameter int LEVELS = LEVELS_DEF,
   parameter int LW     = 7,
   parameter int NIL    = THREADS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [$clog2(LEVELS)-1:0] rd_lv,
   output logic [LW-1:0]             head_rd,
   output logic [LW-1:0]             tail_rd,
   output logic [LEVELS-1:0]         mask,
   output logic [$clog2(LEVELS)-1:0] top_lv,
   input  logic [$clog2(LEVELS)-1:0] wr_lv,
   input  lvl_ctl_type               ctl,
   input  logic [LW-1:0]             head_wr,
   input  logic [LW-1:0]             tail_wr
);

   localparam int LVW = $clog2(LEVELS);

   logic [LW-1:0]     head_ff [LEVELS];
   logic [LW-1:0]     tail_ff [LEVELS];
   logic [LEVELS-1:0] mask_ff;
   logic [LEVELS-1:0] mask_in;
   logic [LEVELS-1:0] wr_bit;

   // read side
   assign head_rd = head_ff[rd_lv];
   assign tail_rd = tail_ff[rd_lv];
   assign mask    = mask_ff;

   // highest set bit of the bitmap
   always_comb begin
      top_lv = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (mask_ff[i]) begin
            top_lv = LVW'(i);
         end
      end
   end

   // bitmap update
   always_comb begin
      wr_bit  = LEVELS'(1) << wr_lv;
      mask_in = mask_ff;
      if (ctl.mask_set) begin
         mask_in = mask_in | wr_bit;
      end
      if (ctl.mask_clr) begin
         mask_in = mask_in & ~wr_bit;
      end
   end

   // pointer and bitmap registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= LW'(NIL);
            tail_ff[i] <= LW'(NIL);
         end
         mask_ff <= '0;
      end else begin
         if (ctl.head_we) begin
            head_ff[wr_lv] <= head_wr;
         end
         if (ctl.tail_we) begin
            tail_ff[wr_lv] <= tail_wr;
         end
         mask_ff <= mask_in;
      end
   end

endmodule

### rtl/bitmap_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue
// Real-time ready queue: per-level doubly linked FIFOs of thread ids with a
// bitmap of non-empty levels.
// ----------------------------------------------------------------------------
// From its transfer until its response is registered, a request goes through
// these steps: the transfer cycle issues the link reads, the next cycle gets
// the read data and does the first link writes plus the head/tail/bitmap
// update, the W2 step does the second link write (one write port per link
// memory bounds this) and loads the response register, waiting in W2 while
// the previous response is still held. A new request is then taken in IDLE,
// even while its response still waits. After reset the queued flags held in
// the previous-link memory are cleared by a pass over every thread id during which no request is taken. Operations:
// enqueue at tail, enqueue at head, dequeue from the highest non-empty level,
// remove a given thread; refused operations answer ok=0 and change nothing.
// ----------------------------------------------------------------------------
module bitmap_priority_ready_queue
   import brq_pkg::*;
#(
   parameter int THREADS = THREADS_DEF,
   parameter int LEVELS  = LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [5:0] thread_id, [9:6] level, rest zero
   input  logic [FUNC_W-1:0]     req_tuser,  // [1:0] func
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [5:0] out_thread, [6] ok, [7] any_ready
);

   localparam int LW  = $clog2(THREADS + 1);
   localparam int AW  = $clog2(THREADS);
   localparam int LVW = $clog2(LEVELS);
   localparam int NIL = THREADS;

   // sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_W1    = 2'd2;
   localparam logic [1:0] ST_W2    = 2'd3;

   function automatic logic is_real(input logic [LW-1:0] x);
      return int'(x) < THREADS;
   endfunction

   function automatic logic [AW-1:0] to_addr(input logic [LW-1:0] x);
      return is_real(x) ? AW'(x) : '0;
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     clr_cnt_ff;
   logic [FUNC_W-1:0] func_ff;
   logic [LW-1:0]     tid_ff;
   logic              treal_ff;
   logic [LVW-1:0]    lv_ff;

   // second-phase link writes
   logic              p2_next_we_ff, p2_prev_we_ff;
   logic [LW-1:0]     p2_addr_ff, p2_data_ff;
   logic              p2_next_we, p2_prev_we;
   logic [LW-1:0]     p2_addr, p2_data;

   // result staging and response register
   logic [TID_W-1:0]      res_thread_ff, res_thread;
   logic                  res_ok_ff, res_ok, res_any_ff, res_any;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // request decode
   logic [TID_W-1:0] in_tid;
   logic [LVL_W-1:0] in_level;
   logic [LVW-1:0]   in_lv_sat, in_lv;
   logic [LW-1:0]    in_link;
   logic             in_real;
   logic             accept;

   // level table
   logic [LVW-1:0]    rd_lv, top_lv;
   logic [LW-1:0]     head_rd, tail_rd, head_wr, tail_wr;
   logic [LEVELS-1:0] mask, mask_after, lv_bit;
   lvl_ctl_type       ctl;

   // link memories: next holds the link, prev holds {queued, link}
   logic          next_we, prev_we;
   logic [AW-1:0] next_waddr, prev_waddr, rd_addr;
   logic [LW-1:0] next_wdata, next_rd;
   logic [LW:0]   prev_wdata, prev_rd;

   // first-phase writes
   logic          n1_we, p1_we;
   logic [LW-1:0] n1_addr, n1_data, p1_addr;
   logic [LW:0]   p1_data;

   // link fields as read for the current item
   logic          q_rd;
   logic [LW-1:0] pv_rd;

   assign in_tid   = req_tdata[TID_W-1:0];
   assign in_level = req_tdata[TID_W+LVL_W-1:TID_W];
   assign in_real  = int'(in_tid) < THREADS;
   assign in_link  = LW'(in_tid);
   assign in_lv_sat = (int'(in_level) >= LEVELS) ? LVW'(LEVELS - 1) : LVW'(in_level);
   assign in_lv    = (req_tuser == FN_DEQ) ? top_lv : in_lv_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign rd_lv   = (state_ff == ST_IDLE) ? in_lv : lv_ff;
   assign rd_addr = (req_tuser == FN_DEQ) ? to_addr(head_rd) : to_addr(in_link);

   assign q_rd  = prev_rd[LW];
   assign pv_rd = prev_rd[LW-1:0];

   brq_level_table #(
      .LEVELS (LEVELS),
      .LW     (LW),
      .NIL    (NIL)
   ) u_level_table (
      .clock   (clock),
      .reset   (reset),
      .rd_lv   (rd_lv),
      .head_rd (head_rd),
      .tail_rd (tail_rd),
      .mask    (mask),
      .top_lv  (top_lv),
      .wr_lv   (lv_ff),
      .ctl     (ctl),
      .head_wr (head_wr),
      .tail_wr (tail_wr)
   );

   brq_link_ram #(
      .DEPTH (THREADS),
      .WIDTH (LW)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   brq_link_ram #(
      .DEPTH (THREADS),
      .WIDTH (LW + 1)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   // list surgery on the data read for this item
   always_comb begin
      ctl        = '0;
      head_wr    = head_rd;
      tail_wr    = tail_rd;
      n1_we      = 1'b0;
      n1_addr    = tid_ff;
      n1_data    = LW'(NIL);
      p1_we      = 1'b0;
      p1_addr    = tid_ff;
      p1_data    = {1'b0, LW'(NIL)};
      p2_next_we = 1'b0;
      p2_prev_we = 1'b0;
      p2_addr    = tid_ff;
      p2_data    = LW'(NIL);
      res_ok     = 1'b0;
      res_thread = '0;
      if (state_ff == ST_W1) begin
         case (func_ff)
            FN_ENQ_TAIL: begin
               if (treal_ff && !q_rd) begin
                  n1_we       = 1'b1;
                  p1_we       = 1'b1;
                  p1_data     = {1'b1, tail_rd};
                  ctl.tail_we = 1'b1;
                  tail_wr     = tid_ff;
                  if (is_real(tail_rd)) begin
                     p2_next_we = 1'b1;
                     p2_addr    = tail_rd;
                     p2_data    = tid_ff;
                  end else begin
                     ctl.head_we = 1'b1;
                     head_wr     = tid_ff;
                  end
                  ctl.mask_set = 1'b1;
                  res_ok       = 1'b1;
               end
            end
            FN_ENQ_HEAD: begin
               if (treal_ff && !q_rd) begin
                  n1_we       = 1'b1;
                  n1_data     = head_rd;
                  p1_we       = 1'b1;
                  p1_data     = {1'b1, LW'(NIL)};
                  ctl.head_we = 1'b1;
                  head_wr     = tid_ff;
                  if (is_real(head_rd)) begin
                     p2_prev_we = 1'b1;
                     p2_addr    = head_rd;
                     p2_data    = tid_ff;
                  end else begin
                     ctl.tail_we = 1'b1;
                     tail_wr     = tid_ff;
                  end
                  ctl.mask_set = 1'b1;
                  res_ok       = 1'b1;
               end
            end
            FN_DEQ: begin
               if (|mask) begin
                  p1_we       = 1'b1;
                  ctl.head_we = 1'b1;
                  head_wr     = next_rd;
                  if (is_real(next_rd)) begin
                     p2_prev_we = 1'b1;
                     p2_addr    = next_rd;
                  end else begin
                     ctl.tail_we  = 1'b1;
                     tail_wr      = LW'(NIL);
                     ctl.mask_clr = 1'b1;
                  end
                  res_ok     = 1'b1;
                  res_thread = TID_W'(tid_ff);
               end
            end
            FN_REMOVE: begin
               if (treal_ff && q_rd
                   && !(!is_real(pv_rd) && head_rd != tid_ff)
                   && !(!is_real(next_rd) && tail_rd != tid_ff)) begin
                  if (is_real(pv_rd)) begin
                     n1_we   = 1'b1;
                     n1_addr = pv_rd;
                     n1_data = next_rd;
                     if (!is_real(head_rd)) begin
                        ctl.mask_clr = 1'b1;
                     end
                  end else begin
                     ctl.head_we = 1'b1;
                     head_wr     = next_rd;
                     if (!is_real(next_rd)) begin
                        ctl.mask_clr = 1'b1;
                     end
                  end
                  if (is_real(next_rd)) begin
                     p2_prev_we = 1'b1;
                     p2_addr    = next_rd;
                     p2_data    = pv_rd;
                  end else begin
                     ctl.tail_we = 1'b1;
                     tail_wr     = pv_rd;
                  end
                  p1_we  = 1'b1;
                  res_ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // bitmap as it stands after this item
   always_comb begin
      lv_bit     = LEVELS'(1) << lv_ff;
      mask_after = mask;
      if (ctl.mask_set) begin
         mask_after = mask_after | lv_bit;
      end
      if (ctl.mask_clr) begin
         mask_after = mask_after & ~lv_bit;
      end
      res_any = |mask_after;
   end

   // link memory write ports
   always_comb begin
      next_we    = 1'b0;
      next_waddr = to_addr(n1_addr);
      next_wdata = n1_data;
      prev_we    = 1'b0;
      prev_waddr = to_addr(p1_addr);
      prev_wdata = p1_data;
      case (state_ff)
         ST_CLEAR: begin
            prev_we    = 1'b1;
            prev_waddr = clr_cnt_ff;
            prev_wdata = {1'b0, LW'(NIL)};
         end
         ST_W1: begin
            next_we = n1_we;
            prev_we = p1_we;
         end
         ST_W2: begin
            next_we    = p2_next_we_ff;
            next_waddr = to_addr(p2_addr_ff);
            next_wdata = p2_data_ff;
            prev_we    = p2_prev_we_ff;
            prev_waddr = to_addr(p2_addr_ff);
            prev_wdata = {1'b1, p2_data_ff};
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == AW'(THREADS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_W1;
            end
         end
         ST_W1: begin
            state_in = ST_W2;
         end
         ST_W2: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         p2_next_we_ff <= 1'b0;
         p2_prev_we_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (state_ff == ST_W1) begin
            p2_next_we_ff <= p2_next_we;
            p2_prev_we_ff <= p2_prev_we;
         end else if (state_ff == ST_W2) begin
            p2_next_we_ff <= 1'b0;
            p2_prev_we_ff <= 1'b0;
         end
         if (state_ff == ST_W2 && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_tuser;
         tid_ff   <= (req_tuser == FN_DEQ) ? head_rd : in_link;
         treal_ff <= in_real;
         lv_ff    <= in_lv;
      end
      if (state_ff == ST_W1) begin
         p2_addr_ff    <= p2_addr;
         p2_data_ff    <= p2_data;
         res_thread_ff <= res_thread;
         res_ok_ff     <= res_ok;
         res_any_ff    <= res_any;
      end
      if (state_ff == ST_W2 && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {res_any_ff, res_ok_ff, res_thread_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### bench/ready_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ready_queue_checker
// Watches the request and response streams of the ready queue and keeps its
// own copy of the per-level lists, links and bitmap. Each request transfer
// produces a predicted response. Each response transfer is compared field by
// field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module ready_queue_checker
   import brq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [5:0] thread_id, [9:6] level, rest zero
   input  logic [FUNC_W-1:0]     req_tuser,  // [1:0] func
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // [5:0] out_thread, [6] ok, [7] any_ready
   output int                    fail_count,
   output int                    pending
);

   localparam int NTHR   = THREADS_DEF;
   localparam int NLVL   = LEVELS_DEF;
   localparam int LINK_W = TID_W + 1;
   localparam logic [LINK_W-1:0] NIL = LINK_W'(NTHR);

   // same bit order as the response payload
   typedef struct packed {
      logic             any_ready;
      logic             ok;
      logic [TID_W-1:0] out_thread;
   } sched_result_type;

   // shadow scheduler state
   logic [LINK_W-1:0] lvl_first [NLVL];
   logic [LINK_W-1:0] lvl_last  [NLVL];
   logic [NLVL-1:0]   busy_levels;
   logic [LINK_W-1:0] link_fwd  [NTHR];
   logic [LINK_W-1:0] link_back [NTHR];
   logic              on_queue  [NTHR];

   sched_result_type  expected_rsp_q [$];
   int                errs  = 0;
   int                depth = 0;

   assign fail_count = errs;
   assign pending    = depth;

   function automatic void clear_lists();
      int i;
      for (i = 0; i < NLVL; i++) begin
         lvl_first[i] = NIL;
         lvl_last[i]  = NIL;
      end
      for (i = 0; i < NTHR; i++) begin
         link_fwd[i]  = NIL;
         link_back[i] = NIL;
         on_queue[i]  = 1'b0;
      end
      busy_levels = '0;
   endfunction

   // apply one operation to the shadow state, return the expected response
   function automatic sched_result_type schedule_op(input logic [FUNC_W-1:0] op,
                                                    input logic [TID_W-1:0]  tid,
                                                    input logic [LVL_W-1:0]  lvl_in);
      sched_result_type  res;
      logic [LINK_W-1:0] cur, pv, nx, old;
      int                lv, i;
      logic              done;
      res  = '0;
      done = 1'b0;
      lv   = int'(lvl_in);
      if (lv >= NLVL) lv = NLVL - 1;
      case (op)
         FN_DEQ: begin
            // priority encoder: highest level with its bitmap bit set
            for (i = NLVL - 1; i >= 0; i--) begin
               if (!done && busy_levels[i]) begin
                  cur = lvl_first[i];
                  if (cur == NIL) begin
                     // stale bitmap bit, drop it and keep searching
                     busy_levels[i] = 1'b0;
                     lvl_last[i]    = NIL;
                  end else begin
                     nx = link_fwd[cur[TID_W-1:0]];
                     lvl_first[i] = nx;
                     if (nx != NIL) begin
                        link_back[nx[TID_W-1:0]] = NIL;
                     end else begin
                        lvl_last[i]    = NIL;
                        busy_levels[i] = 1'b0;
                     end
                     link_fwd[cur[TID_W-1:0]]  = NIL;
                     link_back[cur[TID_W-1:0]] = NIL;
                     on_queue[cur[TID_W-1:0]]  = 1'b0;
                     res.out_thread = cur[TID_W-1:0];
                     res.ok         = 1'b1;
                     done           = 1'b1;
                  end
               end
            end
         end
         FN_REMOVE: begin
            if (on_queue[tid]) begin
               pv = link_back[tid];
               nx = link_fwd[tid];
               // an end of a list only unlinks against the level it heads or ends
               if (!(pv == NIL && lvl_first[lv] != {1'b0, tid}) &&
                   !(nx == NIL && lvl_last[lv] != {1'b0, tid})) begin
                  if (pv != NIL) link_fwd[pv[TID_W-1:0]] = nx;
                  else           lvl_first[lv] = nx;
                  if (nx != NIL) link_back[nx[TID_W-1:0]] = pv;
                  else           lvl_last[lv] = pv;
                  if (lvl_first[lv] == NIL) busy_levels[lv] = 1'b0;
                  link_fwd[tid]  = NIL;
                  link_back[tid] = NIL;
                  on_queue[tid]  = 1'b0;
                  res.ok = 1'b1;
               end
            end
         end
         default: begin
            // enqueue at tail or head; a queued thread is refused
            if (!on_queue[tid]) begin
               if (op == FN_ENQ_TAIL) begin
                  old = lvl_last[lv];
                  link_fwd[tid]  = NIL;
                  link_back[tid] = old;
                  if (old != NIL) link_fwd[old[TID_W-1:0]] = {1'b0, tid};
                  else            lvl_first[lv] = {1'b0, tid};
                  lvl_last[lv] = {1'b0, tid};
               end else begin
                  old = lvl_first[lv];
                  link_back[tid] = NIL;
                  link_fwd[tid]  = old;
                  if (old != NIL) link_back[old[TID_W-1:0]] = {1'b0, tid};
                  else            lvl_last[lv] = {1'b0, tid};
                  lvl_first[lv] = {1'b0, tid};
               end
               busy_levels[lv] = 1'b1;
               on_queue[tid]   = 1'b1;
               res.ok = 1'b1;
            end
         end
      endcase
      res.any_ready = |busy_levels;
      return res;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errs++;
      end
   endfunction

   // responses are matched before the request of the same edge is predicted
   always @(posedge clock) begin
      sched_result_type want, got;
      if (reset) begin
         clear_lists();
         expected_rsp_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rsp_q.size() == 0) begin
               $error("response transfer with no request outstanding: %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_rsp_q.pop_front();
               compare_field("out_thread", int'(want.out_thread), int'(got.out_thread));
               compare_field("ok", int'(want.ok), int'(got.ok));
               compare_field("any_ready", int'(want.any_ready), int'(got.any_ready));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(schedule_op(req_tuser, req_tdata[TID_W-1:0],
                                                 req_tdata[TID_W+LVL_W-1:TID_W]));
      end
      depth = expected_rsp_q.size();
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the bitmap priority ready queue. A directed run covers the
// corner cases, then random phases drive operation mixes that fill, churn
// and drain the level lists, with random gaps and response back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import brq_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int PHASE_ITEMS = 232;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // [5:0] thread_id, [9:6] level, rest zero
   logic [FUNC_W-1:0]     req_tuser  = FN_ENQ_TAIL;  // [1:0] func
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // [5:0] out_thread, [6] ok, [7] any_ready

   int                    fail_count;
   int                    pending;
   int                    idle_pct = 9;
   // level each thread was last enqueued at, steers most removes
   logic [LVL_W-1:0]      home_level [THREADS_DEF];

   always #1 clock = ~clock;

   bitmap_priority_ready_queue u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ready_queue_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // response back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= idle_pct);
   end

   // one request transfer; entered and left at a rising edge
   task automatic send_request(input logic [FUNC_W-1:0] op, input logic [TID_W-1:0] tid,
                               input logic [LVL_W-1:0] lvl);
      int   gap;
      logic taken;
      gap = 0;
      while ($urandom_range(99, 0) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-TID_W-LVL_W){1'b0}}, lvl, tid};
      if (op == FN_ENQ_TAIL || op == FN_ENQ_HEAD) home_level[tid] = lvl;
      // ready is stable by the falling edge
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end
   endtask

   // hold off until every outstanding response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic random_request(input int pool_lo, input int pool_hi, input int deq_pct,
                                 input int rem_pct, input int hot);
      int                roll;
      logic [FUNC_W-1:0] op;
      logic [TID_W-1:0]  tid;
      logic [LVL_W-1:0]  lvl;
      roll = $urandom_range(99, 0);
      tid  = TID_W'($urandom_range(pool_hi, pool_lo));
      if ($urandom_range(99, 0) < 60) lvl = LVL_W'(hot + int'($urandom_range(2, 0)));
      else                            lvl = LVL_W'($urandom_range(15, 0));
      if (roll < deq_pct) begin
         op = FN_DEQ;
      end else if (roll < deq_pct + rem_pct) begin
         op = FN_REMOVE;
         if ($urandom_range(99, 0) < 80) lvl = home_level[tid];
      end else begin
         op = $urandom_range(1, 0) ? FN_ENQ_HEAD : FN_ENQ_TAIL;
      end
      send_request(op, tid, lvl);
   endtask

   // watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[bitmap_priority_ready_queue] ERROR");
      $finish;
   end

   initial begin : stimulus
      int i, p, n;
      for (i = 0; i < THREADS_DEF; i++) home_level[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_request(FN_DEQ,      6'd63, 4'd15);  // dequeue with every level empty
      send_request(FN_REMOVE,   6'd33, 4'd9);   // remove of a thread not queued
      send_request(FN_ENQ_TAIL, 6'd0,  4'd0);
      send_request(FN_ENQ_TAIL, 6'd63, 4'd15);
      send_request(FN_ENQ_HEAD, 6'd5,  4'd15);  // level 15: 5, 63
      send_request(FN_ENQ_TAIL, 6'd63, 4'd2);   // already queued, refused
      send_request(FN_ENQ_HEAD, 6'd42, 4'd0);   // level 0: 42, 0
      send_request(FN_REMOVE,   6'd5,  4'd0);   // head of another level, refused
      send_request(FN_REMOVE,   6'd0,  4'd15);  // tail of another level, refused
      send_request(FN_ENQ_TAIL, 6'd10, 4'd8);
      send_request(FN_ENQ_TAIL, 6'd11, 4'd8);
      send_request(FN_ENQ_TAIL, 6'd12, 4'd8);
      send_request(FN_REMOVE,   6'd11, 4'd3);   // middle of a list, level not needed
      send_request(FN_REMOVE,   6'd12, 4'd8);   // tail
      send_request(FN_REMOVE,   6'd5,  4'd15);  // head
      send_request(FN_DEQ,      6'd0,  4'd0);   // 63 from level 15
      send_request(FN_DEQ,      6'd21, 4'd7);   // 10 from level 8
      send_request(FN_DEQ,      6'd0,  4'd0);   // 42 from level 0
      send_request(FN_REMOVE,   6'd0,  4'd0);   // last thread, bitmap goes empty
      send_request(FN_DEQ,      6'd0,  4'd0);
      send_request(FN_REMOVE,   6'd42, 4'd0);   // already dequeued
      send_request(FN_ENQ_HEAD, 6'd21, 4'd6);
      send_request(FN_ENQ_HEAD, 6'd21, 4'd6);   // head enqueue of a queued thread
      send_request(FN_ENQ_TAIL, 6'd50, 4'd9);
      wait_drained();

      // random phases: fill, wide pool without idling, churn, drain
      for (p = 0; p < 4; p++) begin
         idle_pct = (p == 1) ? 0 : 9;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case (p)
               0:       random_request(0,  15, 20, 25, 4);
               1:       random_request(0,  63, 25, 20, 11);
               2:       random_request(0,  7,  30, 35, 0);
               default: random_request(32, 63, 45, 25, 13);
            endcase
         end
         wait_drained();
      end

      // let any stray response show up
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[bitmap_priority_ready_queue] OK");
      end else begin
         $display("[bitmap_priority_ready_queue] ERROR");
      end
      $finish;
   end

endmodule
